[rtl/ottw_pkg.sv]
`default_nettype none
package ottw_pkg;

  localparam int RowW = 3;
  localparam int ColW = 4;
  localparam int IdxW = 7;
  localparam int StoreDepth = 128;
  localparam int StepW = 4;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CmdWrite     = 2'd0;
  localparam cmd_t CmdSetCursor = 2'd1;
  localparam cmd_t CmdCursorOn  = 2'd2;
  localparam cmd_t CmdCursorOff = 2'd3;

  localparam logic [7:0] SpaceChar = 8'd32;
  localparam logic [7:0] PageCmd   = 8'hB0;
  localparam logic [7:0] ColLoCmd  = 8'h00;
  localparam logic [7:0] ColHiCmd  = 8'h10;

  localparam logic [StepW-1:0] StepPage  = 4'd0;
  localparam logic [StepW-1:0] StepColLo = 4'd1;
  localparam logic [StepW-1:0] StepColHi = 4'd2;
  localparam logic [StepW-1:0] StepData  = 4'd3;
  localparam logic [StepW-1:0] StepLast  = 4'd10;

  typedef struct packed {
    logic            en;
    logic [7:0]      value;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            ul;
  } draw_t;

endpackage
`default_nettype wire

[rtl/ottw_emit.sv]
`default_nettype none
module ottw_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  ottw_pkg::draw_t     draw0_i,
  input  ottw_pkg::draw_t     draw1_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                is_data_o,
  output logic [7:0]          command_byte_o,
  output logic [10:0]         font_address_o,
  output logic                underline_o,
  output logic                end_of_transfer_o,
  output logic                last_o
);

  ottw_pkg::draw_t job_q [2];
  logic busy_q, busy_d;
  logic sel_q, sel_d;
  logic [ottw_pkg::StepW-1:0] step_q, step_d;
  ottw_pkg::draw_t cur;
  logic take;
  logic [ottw_pkg::StepW-1:0] dstep;
  logic [7:0] val_m32;

  assign cur = job_q[sel_q];
  assign out_valid_o = busy_q;
  assign take = busy_q && !out_stall_i;
  assign last_o = (step_q == ottw_pkg::StepLast) && (sel_q || !job_q[1].en);
  assign free_o = !busy_q || (take && last_o);
  assign dstep = step_q - ottw_pkg::StepData;
  assign val_m32 = cur.value - ottw_pkg::SpaceChar;

  always_comb begin
    is_data_o = 1'b0;
    command_byte_o = 8'h00;
    font_address_o = 11'd0;
    underline_o = 1'b0;
    end_of_transfer_o = 1'b0;
    case (step_q)
      ottw_pkg::StepPage: begin
        command_byte_o = ottw_pkg::PageCmd + {5'd0, cur.row};
      end
      ottw_pkg::StepColLo: begin
        command_byte_o = ottw_pkg::ColLoCmd | {4'd0, cur.col[0], 3'd0};
      end
      ottw_pkg::StepColHi: begin
        command_byte_o = ottw_pkg::ColHiCmd | {5'd0, cur.col[3:1]};
        end_of_transfer_o = 1'b1;
      end
      default: begin
        is_data_o = 1'b1;
        font_address_o = {val_m32, dstep[2:0]};
        underline_o = cur.ul;
        end_of_transfer_o = (step_q == ottw_pkg::StepLast);
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    sel_d = sel_q;
    step_d = step_q;
    if (take) begin
      if (step_q == ottw_pkg::StepLast) begin
        step_d = ottw_pkg::StepPage;
        if (!sel_q && job_q[1].en) begin
          sel_d = 1'b1;
        end else begin
          busy_d = 1'b0;
        end
      end else begin
        step_d = step_q + 4'd1;
      end
    end
    if (load_i && free_o) begin
      busy_d = draw0_i.en || draw1_i.en;
      sel_d = !draw0_i.en;
      step_d = ottw_pkg::StepPage;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sel_q <= 1'b0;
      step_q <= ottw_pkg::StepPage;
    end else begin
      busy_q <= busy_d;
      sel_q <= sel_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      job_q[0] <= draw0_i;
      job_q[1] <= draw1_i;
    end
  end

endmodule
`default_nettype wire

[rtl/oled_text_terminal_writer_core.sv]
// Text console front end for a page-mode OLED controller.
// Input channel (in_valid_i / in_stall_o) takes one command per request:
// write character, set cursor, cursor on, cursor off. Output channel
// (out_valid_o / out_stall_i) delivers controller bytes: per glyph redraw
// three command bytes then eight font-address data items, so a request
// yields 0, 11 or 22 output items; last_o flags the final one.
// The first output item follows the request through the character store
// read (read stage) and the emitter load. Throughput: one output item per
// cycle while the receiver does not stall. The next request is accepted
// while the current one drains, so requests follow with no bubble on the
// output side.
// Reset clears the cursor to row 0, column 0, hides it, and marks every
// character cell as a space (per-cell valid bits, no clearing pass).
// When the receiver stalls, the current output item holds and one further
// request is buffered; after that in_stall_o is raised.
`default_nettype none
module oled_text_terminal_writer_core #(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [4:0]  target_column_i,
  input  wire logic [3:0]  target_row_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_data_o,
  output logic [7:0]       command_byte_o,
  output logic [10:0]      font_address_o,
  output logic             underline_o,
  output logic             end_of_transfer_o,
  output logic             last_o
);

  localparam int RowW = ottw_pkg::RowW;
  localparam int ColW = ottw_pkg::ColW;
  localparam int IdxW = ottw_pkg::IdxW;

  logic [7:0] store_mem [ottw_pkg::StoreDepth];
  logic [ottw_pkg::StoreDepth-1:0] cell_ok_q;

  logic [RowW-1:0] cur_row_q, cur_row_d;
  logic [ColW-1:0] cur_col_q, cur_col_d;
  logic shown_q, shown_d;

  logic accept, advance, emit_free;
  logic [RowW-1:0] b_row, adv_row;
  logic [ColW-1:0] b_col, adv_col;
  logic [IdxW-1:0] idx_a, idx_b;
  logic wrap;
  logic tgt_ok;

  // read stage
  logic s1_valid_q;
  logic [7:0] rd_a_q, rd_b_q;
  logic rd_a_ok_q, rd_b_ok_q;
  logic [7:0] s1_ch_q;
  logic s1_use_ch_q, s1_fwd_q;
  logic s1_en0_q, s1_en1_q, s1_ul0_q, s1_ul1_q;
  logic [RowW-1:0] s1_row0_q, s1_row1_q;
  logic [ColW-1:0] s1_col0_q, s1_col1_q;
  logic en0_d, en1_d, ul0_d, ul1_d;

  logic [7:0] val_a, val_b, val0, val1;
  ottw_pkg::draw_t draw0, draw1;

  assign accept = in_valid_i && !in_stall_o;
  assign advance = s1_valid_q && emit_free;
  assign in_stall_o = s1_valid_q && !emit_free;

  assign wrap = ({1'b0, cur_col_q} + 5'd1) == 5'(COLS);
  assign adv_col = wrap ? '0 : cur_col_q + 4'd1;
  assign adv_row = !wrap ? cur_row_q :
                   (({1'b0, cur_row_q} + 4'd1) == 4'(ROWS)) ? '0 : cur_row_q + 3'd1;
  assign tgt_ok = (target_row_i < 4'(ROWS)) && (target_column_i < 5'(COLS));

  always_comb begin
    b_row = cur_row_q;
    b_col = cur_col_q;
    case (command_i)
      ottw_pkg::CmdWrite: begin
        b_row = adv_row;
        b_col = adv_col;
      end
      ottw_pkg::CmdSetCursor: begin
        b_row = target_row_i[RowW-1:0];
        b_col = target_column_i[ColW-1:0];
      end
      default: begin
        b_row = cur_row_q;
        b_col = cur_col_q;
      end
    endcase
  end

  assign idx_a = IdxW'(cur_row_q) * IdxW'(COLS) + IdxW'(cur_col_q);
  assign idx_b = IdxW'(b_row) * IdxW'(COLS) + IdxW'(b_col);

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    shown_d = shown_q;
    en0_d = 1'b0;
    en1_d = 1'b0;
    ul0_d = 1'b0;
    ul1_d = 1'b0;
    case (command_i)
      ottw_pkg::CmdWrite: begin
        cur_row_d = adv_row;
        cur_col_d = adv_col;
        en0_d = 1'b1;
        en1_d = shown_q;
        ul1_d = 1'b1;
      end
      ottw_pkg::CmdSetCursor: begin
        if (tgt_ok) begin
          cur_row_d = b_row;
          cur_col_d = b_col;
          en0_d = shown_q;
          en1_d = shown_q;
          ul1_d = 1'b1;
        end
      end
      ottw_pkg::CmdCursorOn: begin
        shown_d = 1'b1;
        en0_d = 1'b1;
        ul0_d = 1'b1;
      end
      default: begin
        shown_d = 1'b0;
        en0_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      shown_q <= 1'b0;
      s1_valid_q <= 1'b0;
      cell_ok_q <= '0;
    end else begin
      if (accept) begin
        cur_row_q <= cur_row_d;
        cur_col_q <= cur_col_d;
        shown_q <= shown_d;
        if (command_i == ottw_pkg::CmdWrite) begin
          cell_ok_q[idx_a] <= 1'b1;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= store_mem[idx_a];
      rd_b_q <= store_mem[idx_b];
      rd_a_ok_q <= cell_ok_q[idx_a];
      rd_b_ok_q <= cell_ok_q[idx_b];
      if (command_i == ottw_pkg::CmdWrite) begin
        store_mem[idx_a] <= char_code_i;
      end
      s1_ch_q <= char_code_i;
      s1_use_ch_q <= (command_i == ottw_pkg::CmdWrite);
      s1_fwd_q <= (command_i == ottw_pkg::CmdWrite) && (idx_a == idx_b);
      s1_en0_q <= en0_d;
      s1_en1_q <= en1_d;
      s1_ul0_q <= ul0_d;
      s1_ul1_q <= ul1_d;
      s1_row0_q <= cur_row_q;
      s1_col0_q <= cur_col_q;
      s1_row1_q <= b_row;
      s1_col1_q <= b_col;
    end
  end

  assign val_a = rd_a_ok_q ? rd_a_q : ottw_pkg::SpaceChar;
  assign val_b = rd_b_ok_q ? rd_b_q : ottw_pkg::SpaceChar;
  assign val0 = s1_use_ch_q ? s1_ch_q : val_a;
  assign val1 = s1_fwd_q ? s1_ch_q : val_b;

  always_comb begin
    draw0.en = s1_en0_q && (val0 >= ottw_pkg::SpaceChar);
    draw0.value = val0;
    draw0.row = s1_row0_q;
    draw0.col = s1_col0_q;
    draw0.ul = s1_ul0_q;
    draw1.en = s1_en1_q && (val1 >= ottw_pkg::SpaceChar);
    draw1.value = val1;
    draw1.row = s1_row1_q;
    draw1.col = s1_col1_q;
    draw1.ul = s1_ul1_q;
  end

  ottw_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (advance),
    .draw0_i           (draw0),
    .draw1_i           (draw1),
    .free_o            (emit_free),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .is_data_o         (is_data_o),
    .command_byte_o    (command_byte_o),
    .font_address_o    (font_address_o),
    .underline_o       (underline_o),
    .end_of_transfer_o (end_of_transfer_o),
    .last_o            (last_o)
  );

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_row_q} < 4'(ROWS)) && ({1'b0, cur_col_q} < 5'(COLS)))
    else $error("cursor outside the screen");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted request not held in read stage");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled while emitter idle");

endmodule
`default_nettype wire
